@@ rtl/rroc_pkg.sv @@
// Shared constants, types and helper functions for the range overlap counter.
`timescale 1ns / 1ps
`default_nettype none
package rroc_pkg;

    localparam int COORD_W     = 32;
    localparam int BOX_W       = 4 * COORD_W;
    localparam int TOP_ENTRIES = 64;
    localparam int TOP_AW      = $clog2(TOP_ENTRIES);
    localparam int LOCAL_NODES = 128;
    localparam int NODE_AW     = $clog2(LOCAL_NODES);
    localparam int NODE_CAP    = 16;
    localparam int SLOT_W      = $clog2(NODE_CAP);
    localparam int CNT_W       = 5;
    localparam int NODE_W      = BOX_W + 1 + CNT_W;
    localparam int HIT_W       = 12;
    localparam int HIT_MAX     = (1 << HIT_W) - 1;
    localparam int LNC_W       = 8;
    localparam int DIV_W       = 16;
    localparam int RC_W        = 6;
    localparam int GATE_W      = DIV_W + 1;
    localparam int GATE_SPAN   = 3;
    localparam int KW          = $clog2(GATE_SPAN + 1);
    localparam int IN_DATA_W   = 152;
    localparam int OUT_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        MODE_TOP   = 2'd0,
        MODE_NODE  = 2'd1,
        MODE_LEAF  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_NODE_COUNT = 2'd0,
        REG_FANOUT         = 2'd1,
        REG_UNIT_INDEX     = 2'd2,
        REG_ROOT_CHILDREN  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GROUP,
        ST_DIV_GATE,
        ST_GATE_RD,
        ST_GATE_CK,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [LNC_W-1:0] low_node_count;
        logic [DIV_W-1:0] fanout;
        logic [DIV_W-1:0] unit_index;
        logic [RC_W-1:0]  root_children;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [NODE_AW-1:0] index;
        logic [SLOT_W-1:0] slot;
        logic [BOX_W-1:0]  box;
        logic              is_leaf;
        logic [CNT_W-1:0]  entry_count;
    } item_t;

    // Boxes are packed xmin, ymin, xmax, ymax from the lowest bits up.
    function automatic logic box_meets(input logic [BOX_W-1:0] a, input logic [BOX_W-1:0] b);
        logic signed [COORD_W-1:0] axn, ayn, axx, ayx, bxn, byn, bxx, byx;
        axn = a[0*COORD_W +: COORD_W];
        ayn = a[1*COORD_W +: COORD_W];
        axx = a[2*COORD_W +: COORD_W];
        ayx = a[3*COORD_W +: COORD_W];
        bxn = b[0*COORD_W +: COORD_W];
        byn = b[1*COORD_W +: COORD_W];
        bxx = b[2*COORD_W +: COORD_W];
        byx = b[3*COORD_W +: COORD_W];
        return !(axx < bxn || axn > bxx || ayx < byn || ayn > byx);
    endfunction

endpackage
`default_nettype wire

@@ rtl/rroc_div.sv @@
// Iterative unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rroc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rroc_pkg::DIV_W-1:0] dividend,
    input  wire logic [rroc_pkg::DIV_W-1:0] divisor,
    output logic                            done,
    output logic [rroc_pkg::DIV_W-1:0]      quotient
);

    localparam int CW = $clog2(rroc_pkg::DIV_W + 1);

    logic [rroc_pkg::DIV_W-1:0] rem_reg, quo_reg, dvs_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg, done_reg;
    logic [rroc_pkg::DIV_W:0]   shifted;
    logic                       take;

    assign shifted = {rem_reg, quo_reg[rroc_pkg::DIV_W-1]};
    assign take    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(rroc_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? rroc_pkg::DIV_W'(shifted - {1'b0, dvs_reg})
                            : shifted[rroc_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[rroc_pkg::DIV_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ rtl/rroc_front.sv @@
// Input side: takes beats, decodes them into items and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module rroc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rroc_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]                     s_tuser,
    output logic                                item_valid,
    output rroc_pkg::item_t                     item,
    input  wire logic                           item_pop
);

    rroc_pkg::item_t item_in;
    logic            keep, push;
    rroc_pkg::item_t q_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;

    always_comb
    begin
        item_in.mode        = rroc_pkg::mode_t'(s_tuser);
        item_in.index       = s_tdata[6:0];
        item_in.slot        = s_tdata[10:7];
        item_in.box         = s_tdata[138:11];
        item_in.is_leaf     = s_tdata[139];
        item_in.entry_count = s_tdata[144:140];
    end

    // A top entry load beyond the top store has no effect and is dropped here.
    assign keep = !(item_in.mode == rroc_pkg::MODE_TOP &&
                    item_in.index[rroc_pkg::NODE_AW-1:rroc_pkg::TOP_AW] != '0);

    assign s_tready   = cnt_reg != 2'd2;
    assign push       = s_tvalid && s_tready && keep;
    assign item_valid = cnt_reg != 2'd0;
    assign item       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (item_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, item_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rroc_engine.sv @@
// Back end: performs loads into the stores and runs gate check and leaf scan for queries.
`timescale 1ns / 1ps
`default_nettype none
module rroc_engine (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rroc_pkg::cfg_t             cfg,
    input  wire logic                       item_valid,
    input  wire rroc_pkg::item_t            item,
    output logic                            item_pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [rroc_pkg::HIT_W-1:0]      hit_count
);

    localparam int BW = rroc_pkg::BOX_W;
    localparam int NC = rroc_pkg::NODE_CAP;
    localparam int PW = $clog2(NC + 1);

    logic [BW-1:0]                     top_mem [rroc_pkg::TOP_ENTRIES];
    logic [BW-1:0]                     top_rd_reg;
    logic [rroc_pkg::TOP_ENTRIES-1:0]  top_valid_reg;
    logic [rroc_pkg::NODE_W-1:0]       node_mem [rroc_pkg::LOCAL_NODES];
    logic [rroc_pkg::NODE_W-1:0]       node_rd_reg;
    logic [BW-1:0]                     leaf_mem [NC][rroc_pkg::LOCAL_NODES];
    logic [BW-1:0]                     leaf_rd_reg [NC];

    rroc_pkg::state_t                  state_reg, state_next;
    logic [BW-1:0]                     qbox_reg;
    logic [rroc_pkg::GATE_W-1:0]       gate_e_reg, gate_e_next;
    logic [rroc_pkg::KW-1:0]           gate_k_reg, gate_k_next;
    logic [rroc_pkg::LNC_W-1:0]        scan_i_reg, scan_i_next, n_lim;
    logic                              rd_v_reg, hv_v_reg, issue;
    logic [NC-1:0]                     hv_reg, hv_next;
    logic [rroc_pkg::HIT_W-1:0]        acc_reg, acc_next;
    logic                              acc_clear, res_load, q_load;
    logic                              out_valid_reg;
    logic [rroc_pkg::HIT_W-1:0]        hit_reg;

    logic                              div_start, div_done;
    logic [rroc_pkg::DIV_W-1:0]        div_dividend, div_divisor, div_quot;

    logic                              we_top, we_node, we_leaf, gate_hit;
    logic [PW-1:0]                     hv_pop;
    logic [rroc_pkg::CNT_W-1:0]        cnt_lim;
    logic [rroc_pkg::HIT_W:0]          acc_sum;

    rroc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign we_top  = item_pop && item.mode == rroc_pkg::MODE_TOP;
    assign we_node = item_pop && item.mode == rroc_pkg::MODE_NODE;
    assign we_leaf = item_pop && item.mode == rroc_pkg::MODE_LEAF;

    always_ff @(posedge clk)
    begin
        if (we_top)
        begin
            top_mem[item.index[rroc_pkg::TOP_AW-1:0]] <= item.box;
        end
        top_rd_reg <= top_mem[gate_e_reg[rroc_pkg::TOP_AW-1:0]];
        if (we_node)
        begin
            node_mem[item.index] <= {item.entry_count, item.is_leaf, item.box};
        end
        node_rd_reg <= node_mem[scan_i_reg[rroc_pkg::NODE_AW-1:0]];
        for (int b = 0; b < NC; b++)
        begin
            if (we_leaf && item.slot == rroc_pkg::SLOT_W'(b))
            begin
                leaf_mem[b][item.index] <= item.box;
            end
            leaf_rd_reg[b] <= leaf_mem[b][scan_i_reg[rroc_pkg::NODE_AW-1:0]];
        end
    end

    assign n_lim = (cfg.low_node_count > rroc_pkg::LNC_W'(rroc_pkg::LOCAL_NODES))
                   ? rroc_pkg::LNC_W'(rroc_pkg::LOCAL_NODES) : cfg.low_node_count;

    assign gate_hit = gate_e_reg < rroc_pkg::GATE_W'(rroc_pkg::TOP_ENTRIES) &&
                      top_valid_reg[gate_e_reg[rroc_pkg::TOP_AW-1:0]] &&
                      rroc_pkg::box_meets(top_rd_reg, qbox_reg);

    always_comb
    begin
        cnt_lim = node_rd_reg[rroc_pkg::NODE_W-1 -: rroc_pkg::CNT_W];
        if (cnt_lim > rroc_pkg::CNT_W'(NC))
        begin
            cnt_lim = rroc_pkg::CNT_W'(NC);
        end
        for (int j = 0; j < NC; j++)
        begin
            hv_next[j] = rroc_pkg::box_meets(node_rd_reg[BW-1:0], qbox_reg) &&
                         node_rd_reg[BW] &&
                         rroc_pkg::CNT_W'(j) < cnt_lim &&
                         rroc_pkg::box_meets(leaf_rd_reg[j], qbox_reg);
        end
    end

    always_comb
    begin
        hv_pop = '0;
        for (int j = 0; j < NC; j++)
        begin
            hv_pop = hv_pop + PW'(hv_reg[j]);
        end
        acc_sum = {1'b0, acc_reg} + (rroc_pkg::HIT_W + 1)'(hv_pop);
        if (acc_clear)
        begin
            acc_next = '0;
        end
        else if (hv_v_reg)
        begin
            acc_next = acc_sum > (rroc_pkg::HIT_W + 1)'(rroc_pkg::HIT_MAX)
                       ? rroc_pkg::HIT_W'(rroc_pkg::HIT_MAX) : acc_sum[rroc_pkg::HIT_W-1:0];
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        gate_e_next  = gate_e_reg;
        gate_k_next  = gate_k_reg;
        scan_i_next  = scan_i_reg;
        item_pop     = 1'b0;
        q_load       = 1'b0;
        acc_clear    = 1'b0;
        issue        = 1'b0;
        res_load     = 1'b0;
        div_start    = 1'b0;
        div_dividend = cfg.fanout;
        div_divisor  = rroc_pkg::DIV_W'(cfg.root_children);
        case (state_reg)
            rroc_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    if (item.mode == rroc_pkg::MODE_QUERY)
                    begin
                        q_load      = 1'b1;
                        acc_clear   = 1'b1;
                        gate_e_next = '0;
                        gate_k_next = '0;
                        if (cfg.root_children != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = rroc_pkg::ST_DIV_GROUP;
                        end
                        else
                        begin
                            state_next = rroc_pkg::ST_GATE_RD;
                        end
                    end
                end
            end
            rroc_pkg::ST_DIV_GROUP:
            begin
                div_dividend = cfg.unit_index;
                div_divisor  = div_quot;
                if (div_done)
                begin
                    if (div_quot == '0)
                    begin
                        state_next = rroc_pkg::ST_GATE_RD;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = rroc_pkg::ST_DIV_GATE;
                    end
                end
            end
            rroc_pkg::ST_DIV_GATE:
            begin
                if (div_done)
                begin
                    gate_e_next = (div_quot == '0) ? '0
                                  : rroc_pkg::GATE_W'(div_quot) - 1'b1;
                    state_next  = rroc_pkg::ST_GATE_RD;
                end
            end
            rroc_pkg::ST_GATE_RD:
            begin
                state_next = rroc_pkg::ST_GATE_CK;
            end
            rroc_pkg::ST_GATE_CK:
            begin
                if (gate_hit)
                begin
                    scan_i_next = '0;
                    state_next  = rroc_pkg::ST_SCAN;
                end
                else if (gate_k_reg == rroc_pkg::KW'(rroc_pkg::GATE_SPAN))
                begin
                    state_next = rroc_pkg::ST_RESULT;
                end
                else
                begin
                    gate_e_next = gate_e_reg + 1'b1;
                    gate_k_next = gate_k_reg + 1'b1;
                    state_next  = rroc_pkg::ST_GATE_RD;
                end
            end
            rroc_pkg::ST_SCAN:
            begin
                if (scan_i_reg < n_lim)
                begin
                    issue       = 1'b1;
                    scan_i_next = scan_i_reg + 1'b1;
                end
                else
                begin
                    state_next = rroc_pkg::ST_DRAIN;
                end
            end
            rroc_pkg::ST_DRAIN:
            begin
                if (!rd_v_reg && !hv_v_reg)
                begin
                    state_next = rroc_pkg::ST_RESULT;
                end
            end
            rroc_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    res_load   = 1'b1;
                    state_next = rroc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rroc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rroc_pkg::ST_IDLE;
            top_valid_reg <= '0;
            rd_v_reg      <= 1'b0;
            hv_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (we_top)
            begin
                top_valid_reg[item.index[rroc_pkg::TOP_AW-1:0]] <= 1'b1;
            end
            rd_v_reg <= issue;
            hv_v_reg <= rd_v_reg;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gate_e_reg <= gate_e_next;
        gate_k_reg <= gate_k_next;
        scan_i_reg <= scan_i_next;
        hv_reg     <= hv_next;
        acc_reg    <= acc_next;
        if (q_load)
        begin
            qbox_reg <= item.box;
        end
        if (res_load)
        begin
            hit_reg <= acc_reg;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign hit_count = hit_reg;

endmodule
`default_nettype wire

@@ rtl/rtree_range_overlap_count.sv @@
// Top level of the range overlap counter: configuration registers, front queue and engine.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_tvalid/s_tready  | tuser: mode; tdata: index, slot, box, is_leaf, count
//  m_      | out       | m_tvalid/m_tready  | tdata: hit_count
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A load beat is written into its store as the engine takes it from the queue. A query first
// runs up to two divisions for the gate index (16 steps each), then checks up to four top
// entries from that index, stopping at the first hit; on a hit it scans the local nodes, one
// node per cycle, drains the read pipeline and posts the result. The node and leaf memories
// deliver one node and all its slots per cycle, which sets the scan rate. Reset clears
// control state and the top entry valid bits; the stores hold no reset. A two-beat queue
// lets the input side accept up to two beats while the engine is busy.
`timescale 1ns / 1ps
`default_nettype none
module rtree_range_overlap_count (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // index[6:0], slot[10:7], rect_xmin[42:11], rect_ymin[74:43], rect_xmax[106:75],
    // rect_ymax[138:107], is_leaf[139], entry_count[144:140], zero fill above.
    input  wire logic [rroc_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode[1:0].
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // hit_count[11:0], zero fill above.
    output logic [rroc_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rroc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rroc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rroc_pkg::cfg_t              cfg_reg;
    rroc_pkg::item_t             item;
    logic                        item_valid, item_pop;
    logic [rroc_pkg::HIT_W-1:0]  hit_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (rroc_pkg::reg_idx_t'(cfg_index))
                rroc_pkg::REG_LOW_NODE_COUNT:
                    cfg_reg.low_node_count <= cfg_data[rroc_pkg::LNC_W-1:0];
                rroc_pkg::REG_FANOUT:
                    cfg_reg.fanout <= cfg_data;
                rroc_pkg::REG_UNIT_INDEX:
                    cfg_reg.unit_index <= cfg_data;
                rroc_pkg::REG_ROOT_CHILDREN:
                    cfg_reg.root_children <= cfg_data[rroc_pkg::RC_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    rroc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    rroc_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .hit_count  (hit_count)
    );

    assign m_tdata = {{(rroc_pkg::OUT_DATA_W - rroc_pkg::HIT_W){1'b0}}, hit_count};

endmodule
`default_nettype wire
